@@ sv/swm_pkg.sv @@
// Shared types and constants for the sliding-window median filter.
package swm_pkg;

  localparam int SampleBits = 24;
  localparam int MedianBits = SampleBits + 1;
  localparam int CfgBits    = 7;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [MedianBits-1:0] median_x2;
    logic                         end_of_stream;
  } out_beat_t;

  // Broadcast to every cell of the sorted row.
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;   // value entering the window
    logic signed [SampleBits-1:0] evict;    // value leaving the window
    logic                         remove;   // window full: drop evict first
    logic                         update;   // load the new ordering
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT
  } swm_state_e;

endpackage

@@ sv/sliding_window_median_top.sv @@
// Sliding-window median filter: top level with control, arrival ring and cell row.
// Keeps the last window_size samples in a row of sorting cells, ordered ascending,
// plus a ring of the same samples in arrival order to know which value leaves.
// A sample that gives a result passes through accept (the ring read of the
// oldest sample), one cell-row update where every cell removes and inserts in
// parallel, and the result load; a sample that gives no result skips the load.
// The ring read is registered, and the median is read from the updated cells.
// The result load waits while an earlier result is still stalled at the output.
// Results appear once the window is full (median_x2 is twice the median) or for
// a sample marked last (median_x2 is zero if the window was not yet full), after
// which the window is empty. A result may wait at the output while the next
// sample enters. Writing window_size empties the window; no clearing pass is
// needed after reset.
module sliding_window_median_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swm_pkg::CfgBits-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  swm_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output swm_pkg::out_beat_t            out_data_o
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  swm_state_e state_q, state_d;

  logic [CfgBits-1:0]           wsize_q;
  logic [CW-1:0]                win;
  logic [CW-1:0]                count_q, count_d;
  logic [PW-1:0]                ptr_q, ptr_d;
  logic signed [SampleBits-1:0] smp_q;
  logic                         last_q;
  logic                         remove_q;
  logic                         full_q, full_d;
  logic signed [SampleBits-1:0] evict_q;
  logic signed [SampleBits-1:0] ring [MAX_WINDOW];
  logic [PW-1:0]                wr_addr;
  logic                         cfg_wr;
  logic                         in_acc;
  logic                         do_update;
  logic                         load_out;
  logic                         out_valid_q;
  out_beat_t                    out_q;
  cell_ctrl_t                   ctrl;
  logic [MAX_WINDOW-1:0]        occ;
  logic signed [SampleBits-1:0] vals  [MAX_WINDOW];
  logic signed [SampleBits-1:0] shv   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]        below;
  logic [CW-1:0]                half_lo, half_hi;
  logic [PW-1:0]                mid_lo, mid_hi;
  logic signed [MedianBits-1:0] med_sum;

  // Effective window: zero acts as one, oversize clamps to the row length.
  always_comb begin
    if (wsize_q == '0) begin
      win = CW'(1);
    end else if (int'(wsize_q) > MAX_WINDOW) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(wsize_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_UPDATE;
      ST_UPDATE: state_d = (full_d || last_q) ? ST_RESULT : ST_IDLE;
      ST_RESULT: if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = 1'b1;
    do_update  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_UPDATE: do_update  = 1'b1;
      ST_RESULT: load_out   = !out_valid_q || !out_stall_i;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // Window bookkeeping
  always_comb begin
    full_d  = remove_q || ((count_q + CW'(1)) == win);
    count_d = count_q;
    ptr_d   = ptr_q;
    if (cfg_wr) begin
      count_d = '0;
      ptr_d   = '0;
    end else if (do_update) begin
      if (last_q) begin
        count_d = '0;
        ptr_d   = '0;
      end else if (remove_q) begin
        ptr_d = ((CW'(ptr_q) + CW'(1)) >= win) ? '0 : ptr_q + PW'(1);
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wsize_q     <= CfgBits'(64);
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (cfg_wr) begin
        wsize_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat capture and flags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q    <= in_data_i.sample;
      last_q   <= in_data_i.last_sample;
      remove_q <= (count_q == win);
    end
    if (do_update) begin
      full_q <= full_d;
    end
  end

  // Arrival ring: fetch the oldest sample on accept, store the new one on update.
  assign wr_addr = remove_q ? ptr_q : count_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      evict_q <= ring[ptr_q];
    end
    if (do_update) begin
      ring[wr_addr] <= smp_q;
    end
  end

  // Cell row
  always_comb begin
    ctrl.sample = smp_q;
    ctrl.evict  = evict_q;
    ctrl.remove = remove_q;
    ctrl.update = do_update;
  end

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    logic signed [SampleBits-1:0] up_val;
    logic                         up_occ;
    logic signed [SampleBits-1:0] dn_val;
    logic                         dn_below;

    assign occ[j] = (CW'(j) < count_q);

    if (j == MAX_WINDOW - 1) begin : g_top
      assign up_val = '0;
      assign up_occ = 1'b0;
    end else begin : g_mid
      assign up_val = vals[j+1];
      assign up_occ = occ[j+1];
    end

    if (j == 0) begin : g_bot
      assign dn_val   = '0;
      assign dn_below = 1'b1;
    end else begin : g_up
      assign dn_val   = shv[j-1];
      assign dn_below = below[j-1];
    end

    swm_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (occ[j]),
      .up_val_i       (up_val),
      .up_occ_i       (up_occ),
      .dn_shift_val_i (dn_val),
      .dn_below_i     (dn_below),
      .val_o          (vals[j]),
      .shift_val_o    (shv[j]),
      .below_o        (below[j])
    );
  end

  // Twice the median: both middle entries, the same one for an odd window.
  always_comb begin
    half_lo = (win - CW'(1)) >> 1;
    half_hi = win >> 1;
    mid_lo  = half_lo[PW-1:0];
    mid_hi  = half_hi[PW-1:0];
    med_sum = {vals[mid_lo][SampleBits-1], vals[mid_lo]}
            + {vals[mid_hi][SampleBits-1], vals[mid_hi]};
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.median_x2     <= full_q ? med_sum : '0;
      out_q.end_of_stream <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/swm_cell.sv @@
// One slot of the sorted window: removes the evicted value and inserts the new one.
module swm_cell (
  input  logic                                 clk_i,
  input  swm_pkg::cell_ctrl_t                  ctrl_i,
  input  logic                                 occ_i,
  input  logic signed [swm_pkg::SampleBits-1:0] up_val_i,
  input  logic                                 up_occ_i,
  input  logic signed [swm_pkg::SampleBits-1:0] dn_shift_val_i,
  input  logic                                 dn_below_i,
  output logic signed [swm_pkg::SampleBits-1:0] val_o,
  output logic signed [swm_pkg::SampleBits-1:0] shift_val_o,
  output logic                                 below_o
);
  import swm_pkg::*;

  logic signed [SampleBits-1:0] val_q;
  logic signed [SampleBits-1:0] val_d;
  logic                         take_up;
  logic                         shift_occ;

  always_comb begin
    // The slot at or above the evicted entry closes the gap from above.
    take_up     = ctrl_i.remove && occ_i && (val_q >= ctrl_i.evict);
    shift_val_o = take_up ? up_val_i : val_q;
    shift_occ   = take_up ? up_occ_i : occ_i;
    below_o     = shift_occ && (shift_val_o <= ctrl_i.sample);
    // Keep own value below the insertion point, take the sample at it, shift above it.
    if (below_o) begin
      val_d = shift_val_o;
    end else if (dn_below_i) begin
      val_d = ctrl_i.sample;
    end else begin
      val_d = dn_shift_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule
